[hw/rtl/skf_pkg.sv]
// Shared types and constants for the scalar Kalman filter unit.
// No dependencies; imported by the sequencer, the datapath and the top level.
package skf_pkg;

  localparam int VAL_W     = 32;   // Q16.16 estimate, variance, noise terms
  localparam int GAIN_W    = 17;   // Q1.16 gain, 65536 is one
  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = 5;

  localparam logic [CNT_W-1:0]  ITER_LAST = 5'd16;   // 17 steps per loop
  localparam logic [GAIN_W-1:0] ONE_Q16   = 17'h10000;
  localparam logic [VAL_W-1:0]  Q_RESET   = 32'd1310720;
  localparam logic [VAL_W-1:0]  R_RESET   = 32'd13107200;

  typedef enum logic [0:0] {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,    // Ppred = sat(P + Q)
    ST_DEN,     // denom = Ppred + R
    ST_DIV,     // one restoring divide step per cycle
    ST_INNOV,   // innovation = z - estimate
    ST_MUL1,    // gain * innovation, shift-add
    ST_ROUND,   // bias negative product toward zero
    ST_EST,     // estimate + delta, saturated
    ST_ONEMG,   // 1 - gain
    ST_MUL2,    // (1 - gain) * Ppred, shift-add
    ST_DONE
  } state_t;

  typedef struct packed {
    state_t op;
    logic   first;
    logic   start;
    logic   commit;
  } skf_ctrl_t;

endpackage

[hw/rtl/scalar_kalman_filter_unit.sv]
// Top level of the scalar Kalman filter: noise registers, result register,
// sequencer and datapath. Depends on skf_pkg, skf_seq and skf_dp.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  in_sample
//   out      source     out_valid/out_stall  out_estimate, out_gain
//   cfg      sink       cfg_we               cfg_index, cfg_wdata
//
// A sample runs from its transfer to the result register through three
// 17-step loops (gain divide, two shift-add multiplies) and seven single steps,
// all on one shared 51-bit adder (default SAMPLE_BITS). The next sample is taken
// in the cycle after at the earliest; in_stall holds new samples off until then.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result holds; the next sample may run meanwhile and waits at its end.
module scalar_kalman_filter_unit import skf_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VAL_W-1:0]       out_estimate,
  output logic [GAIN_W-1:0]      out_gain,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [VAL_W-1:0]       cfg_wdata
);

  logic [VAL_W-1:0]  q_r, q_nxt;
  logic [VAL_W-1:0]  r_r, r_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_est_r;
  logic [GAIN_W-1:0] out_gain_r;
  logic              out_free;
  skf_ctrl_t         ctrl;
  logic [VAL_W-1:0]  dp_estimate;
  logic [GAIN_W-1:0] dp_gain;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROCESS_NOISE:     q_nxt = cfg_wdata;
        REG_MEASUREMENT_NOISE: r_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r         <= Q_RESET;
      r_r         <= R_RESET;
      out_valid_r <= 1'b0;
    end else begin
      q_r         <= q_nxt;
      r_r         <= r_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the result register when the update commits
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_est_r  <= dp_estimate;
      out_gain_r <= dp_gain;
    end
  end

  skf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  skf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .cfg_clear         (cfg_we),
    .process_noise     (q_r),
    .measurement_noise (r_r),
    .sample            (in_sample),
    .estimate          (dp_estimate),
    .gain              (dp_gain)
  );

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_gain     = out_gain_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !ctrl.commit)
    else $error("result overwritten while stalled");

  a_out_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_gain_r <= ONE_Q16))
    else $error("result gain above one");

endmodule

[hw/rtl/skf_seq.sv]
// Sequencer for the scalar Kalman filter: steps the shared adder through
// one filter update. Depends on skf_pkg.
module skf_seq import skf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_free,
  output logic      in_stall,
  output skf_ctrl_t ctrl
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              last_iter;

  assign last_iter = (cnt_r == ITER_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PRED;
      ST_PRED:  state_nxt = ST_DEN;
      ST_DEN:   state_nxt = ST_DIV;
      ST_DIV:   if (last_iter) state_nxt = ST_INNOV;
      ST_INNOV: state_nxt = ST_MUL1;
      ST_MUL1:  if (last_iter) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_EST;
      ST_EST:   state_nxt = ST_ONEMG;
      ST_ONEMG: state_nxt = ST_MUL2;
      ST_MUL2:  if (last_iter) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = '0;
    if ((state_r == ST_DIV || state_r == ST_MUL1 || state_r == ST_MUL2) && !last_iter) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    ctrl.op     = state_r;
    ctrl.first  = (cnt_r == '0);
    ctrl.start  = (state_r == ST_IDLE) && in_valid;
    ctrl.commit = (state_r == ST_DONE) && out_free;
  end

  a_start_pred: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> state_r == ST_PRED)
    else $error("transfer did not start an update");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |=> state_r == ST_IDLE)
    else $error("sequencer did not return to idle after commit");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && last_iter) |=> state_r == ST_INNOV)
    else $error("divide loop ran past its last step");

endmodule

[hw/rtl/skf_dp.sv]
// Datapath of the scalar Kalman filter: one shared adder/subtractor that does
// the divide steps, both shift-add multiplies and the sums. Depends on skf_pkg.
module skf_dp import skf_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  skf_ctrl_t               ctrl,
  input  logic                    cfg_clear,
  input  logic [VAL_W-1:0]        process_noise,
  input  logic [VAL_W-1:0]        measurement_noise,
  input  logic [SAMPLE_BITS-1:0]  sample,
  output logic [VAL_W-1:0]        estimate,
  output logic [GAIN_W-1:0]       gain
);

  localparam int ZW = SAMPLE_BITS + FRAC_BITS;
  localparam int IW = ((ZW > VAL_W) ? ZW : VAL_W) + 1;
  localparam int PW = IW + GAIN_W;
  localparam int AW = (PW > VAL_W + GAIN_W + 1) ? PW : (VAL_W + GAIN_W + 1);
  localparam int SW = AW + 1;
  localparam int DW = VAL_W + 1;   // denominator
  localparam int RW = VAL_W + 2;   // partial remainder, doubled

  logic [VAL_W-1:0]       est_r, est_nxt;
  logic [VAL_W-1:0]       p_r, p_nxt;
  logic [SAMPLE_BITS-1:0] z_r, z_nxt;
  logic [VAL_W-1:0]       ppred_r, ppred_nxt;
  logic [DW-1:0]          denom_r, denom_nxt;
  logic [RW-1:0]          rem_r, rem_nxt;
  logic [GAIN_W-1:0]      quo_r, quo_nxt;
  logic [AW-1:0]          mcand_r, mcand_nxt;
  logic [GAIN_W-1:0]      mult_r, mult_nxt;
  logic [AW-1:0]          acc_r, acc_nxt;

  logic [SW-1:0]          opa, opb, sum;
  logic                   sub;
  logic [RW-1:0]          cand;
  logic [ZW-1:0]          zval;
  logic                   neg;
  logic                   ovf;

  assign cand = ctrl.first ? rem_r : {rem_r[RW-2:0], 1'b0};
  assign zval = {z_r, {FRAC_BITS{1'b0}}};

  // shared adder
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    unique case (ctrl.op)
      ST_PRED: begin
        opa = {{(SW-VAL_W){1'b0}}, p_r};
        opb = {{(SW-VAL_W){1'b0}}, process_noise};
      end
      ST_DEN: begin
        opa = {{(SW-VAL_W){1'b0}}, ppred_r};
        opb = {{(SW-VAL_W){1'b0}}, measurement_noise};
      end
      ST_DIV: begin
        opa = {{(SW-RW){1'b0}}, cand};
        opb = {{(SW-DW){1'b0}}, denom_r};
        sub = 1'b1;
      end
      ST_INNOV: begin
        opa = {{(SW-ZW){zval[ZW-1]}}, zval};
        opb = {{(SW-VAL_W){est_r[VAL_W-1]}}, est_r};
        sub = 1'b1;
      end
      ST_MUL1, ST_MUL2: begin
        opa = {acc_r[AW-1], acc_r};
        opb = mult_r[0] ? {mcand_r[AW-1], mcand_r} : '0;
      end
      ST_ROUND: begin
        opa = {acc_r[AW-1], acc_r};
        opb = acc_r[AW-1] ? SW'({FRAC_BITS{1'b1}}) : '0;
      end
      ST_EST: begin
        opa = {{(SW-VAL_W){est_r[VAL_W-1]}}, est_r};
        opb = {{(FRAC_BITS+1){acc_r[AW-1]}}, acc_r[AW-1:FRAC_BITS]};
      end
      ST_ONEMG: begin
        opa = {{(SW-GAIN_W){1'b0}}, ONE_Q16};
        opb = {{(SW-GAIN_W){1'b0}}, quo_r};
        sub = 1'b1;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    sum = opa + (sub ? ~opb : opb) + {{(SW-1){1'b0}}, sub};
  end

  assign neg = sum[SW-1];
  assign ovf = (sum[SW-1:VAL_W-1] != '0) && (sum[SW-1:VAL_W-1] != '1);

  always_comb begin
    est_nxt   = est_r;
    p_nxt     = p_r;
    z_nxt     = z_r;
    ppred_nxt = ppred_r;
    denom_nxt = denom_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    mcand_nxt = mcand_r;
    mult_nxt  = mult_r;
    acc_nxt   = acc_r;
    if (ctrl.start) begin
      z_nxt = sample;
    end
    if (ctrl.commit) begin
      p_nxt = acc_r[VAL_W+FRAC_BITS-1:FRAC_BITS];
    end
    unique case (ctrl.op)
      ST_PRED: ppred_nxt = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
      ST_DEN: begin
        denom_nxt = sum[DW-1:0];
        rem_nxt   = {2'b00, ppred_r};
        quo_nxt   = '0;
      end
      ST_DIV: begin
        // keep the difference when it did not go negative; zero divisor gives 0
        rem_nxt = neg ? cand : sum[RW-1:0];
        quo_nxt = {quo_r[GAIN_W-2:0], !neg && (denom_r != '0)};
      end
      ST_INNOV: begin
        mcand_nxt = sum[AW-1:0];
        mult_nxt  = quo_r;
        acc_nxt   = '0;
      end
      ST_MUL1, ST_MUL2: begin
        acc_nxt   = sum[AW-1:0];
        mcand_nxt = {mcand_r[AW-2:0], 1'b0};
        mult_nxt  = {1'b0, mult_r[GAIN_W-1:1]};
      end
      ST_ROUND: acc_nxt = sum[AW-1:0];
      ST_EST: begin
        if (ovf) begin
          est_nxt = neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
          est_nxt = sum[VAL_W-1:0];
        end
        mcand_nxt = {{(AW-VAL_W){1'b0}}, ppred_r};
        acc_nxt   = '0;
      end
      ST_ONEMG: mult_nxt = sum[GAIN_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      est_r <= '0;
      p_r   <= '0;
    end else begin
      est_r <= est_nxt;
      p_r   <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r     <= z_nxt;
    ppred_r <= ppred_nxt;
    denom_r <= denom_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
    acc_r   <= acc_nxt;
  end

  assign estimate = est_r;
  assign gain     = quo_r;

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> (est_r == '0) && (p_r == '0))
    else $error("register write did not clear the filter state");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == ST_INNOV) |-> (quo_r <= ONE_Q16))
    else $error("gain above one after divide");

endmodule

[dv/scalar_kalman_filter_unit_tb.sv]
// Self-checking testbench for scalar_kalman_filter_unit: drives sensor samples and
// noise register writes, predicts estimate and gain per sample in a scoreboard class.
// Depends on skf_pkg and the scalar_kalman_filter_unit RTL.
module scalar_kalman_filter_unit_tb;
  import skf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS  = 16;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int RESULT_DELAY = 70;   // margin past the sample latency
  localparam int RANDOM_ITEMS = 1400;

  localparam logic [VAL_W-1:0] NOISE_MAX = '1;

  // Holds the filter state and noise terms and the estimates still owed by the block.
  class kalman_scoreboard;
    logic [VAL_W-1:0]  q_noise;
    logic [VAL_W-1:0]  r_noise;
    int                estimate;
    logic [VAL_W-1:0]  variance;
    logic [VAL_W-1:0]  estimate_q[$];
    logic [GAIN_W-1:0] gain_q[$];
    int                errors;

    function new();
      q_noise  = Q_RESET;
      r_noise  = R_RESET;
      estimate = 0;
      variance = '0;
      errors   = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Either noise write clears the filter state.
    function void write_noise(cfg_reg_t idx, logic [VAL_W-1:0] value);
      if (idx == REG_PROCESS_NOISE) q_noise = value;
      else                          r_noise = value;
      estimate = 0;
      variance = '0;
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] raw);
      longint          meas;
      longint          innov;
      longint          delta;
      longint          next_est;
      longint unsigned ppred;
      longint unsigned denom;
      longint unsigned gain;
      meas  = longint'($signed(raw)) * 65536;
      ppred = longint'({32'b0, variance}) + longint'({32'b0, q_noise});
      if (ppred > 64'hFFFF_FFFF) ppred = 64'hFFFF_FFFF;
      denom = ppred + longint'({32'b0, r_noise});
      gain  = 0;
      if (denom != 0) gain = (ppred << FRAC_BITS) / denom;
      if (gain > 65536) gain = 65536;
      innov    = meas - longint'(estimate);
      delta    = (longint'(gain) * innov) / 65536;
      next_est = longint'(estimate) + delta;
      if (next_est > 64'sd2147483647) next_est = 64'sd2147483647;
      if (next_est < -64'sd2147483648) next_est = -64'sd2147483648;
      estimate = int'(next_est);
      variance = VAL_W'(((65536 - gain) * ppred) >> FRAC_BITS);
      estimate_q.push_back(VAL_W'(estimate));
      gain_q.push_back(GAIN_W'(gain));
    endfunction

    function int pending();
      return estimate_q.size();
    endfunction

    task check_result(logic [VAL_W-1:0] est, logic [GAIN_W-1:0] gain);
      logic [VAL_W-1:0]  want_est;
      logic [GAIN_W-1:0] want_gain;
      if (estimate_q.size() == 0) begin
        report($sformatf("result est=%h gain=%h with no sample outstanding", est, gain));
      end else begin
        want_est  = estimate_q.pop_front();
        want_gain = gain_q.pop_front();
        if (est !== want_est)
          report($sformatf("estimate %h, expected %h", est, want_est));
        if (gain !== want_gain)
          report($sformatf("gain %h, expected %h", gain, want_gain));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic [VAL_W-1:0]       out_estimate;
  logic [GAIN_W-1:0]      out_gain;
  logic                   cfg_we;
  logic [0:0]             cfg_index;
  logic [VAL_W-1:0]       cfg_wdata;

  kalman_scoreboard sb;
  int               cycle_count;
  int               burst_left;
  int               stall_left;
  int               stall_mode;
  int               sent;
  int               n_items;
  int               level;

  scalar_kalman_filter_unit #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_estimate (out_estimate),
    .out_gain     (out_gain),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_estimate, out_gain);
  end

  // Receiver: alternate between free-running, random stalls and solid stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = (stall_mode == 2) ? $urandom_range(1, 150) : $urandom_range(20, 400);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= 1'b1;
    endcase
  end

  task automatic write_noise(cfg_reg_t idx, logic [VAL_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_noise(idx, value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Present one sample and hold it until the transfer; a finished burst is mostly followed by a gap.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] value);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (in_stall);
    sb.note_sample(value);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 140);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_noise();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return NOISE_MAX;
      2:       return $urandom_range(0, 1 << 20);
      3:       return VAL_W'($urandom_range(1, 64)) << $urandom_range(8, 26);
      default: return $urandom;
    endcase
  endfunction

  // Mostly a steady level with sensor noise, some wild samples and extremes.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int lvl);
    int v;
    case ($urandom_range(0, 9))
      0:       return SAMPLE_BITS'($urandom);
      1:       return $urandom_range(0, 1) ? SAMPLE_BITS'(32767) : SAMPLE_BITS'(-32768);
      default: begin
        v = lvl + int'($urandom_range(0, 400)) - 200;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SAMPLE_BITS'(v);
      end
    endcase
  endfunction

  initial begin
    sb          = new();
    cycle_count = 0;
    stall_left  = 0;
    stall_mode  = 0;
    burst_left  = 1;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_sample   = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_PROCESS_NOISE;
    cfg_wdata   = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset noise terms: sample extremes and bit patterns.
    send_sample(SAMPLE_BITS'(32767));
    send_sample(SAMPLE_BITS'(-32768));
    send_sample(SAMPLE_BITS'(0));
    send_sample(SAMPLE_BITS'(-1));
    send_sample(SAMPLE_BITS'(1));
    send_sample(SAMPLE_BITS'(32767));
    send_sample(SAMPLE_BITS'(32767));
    send_sample(SAMPLE_BITS'(-32768));
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    drain(8);

    // Both noise terms zero: zero denominator, gain 0, estimate holds.
    write_noise(REG_PROCESS_NOISE, '0);
    write_noise(REG_MEASUREMENT_NOISE, '0);
    send_sample(SAMPLE_BITS'(32767));
    send_sample(SAMPLE_BITS'(-32768));
    send_sample(SAMPLE_BITS'(1234));
    drain(8);

    // Huge Q, no R: gain of exactly one.
    write_noise(REG_PROCESS_NOISE, NOISE_MAX);
    send_sample(SAMPLE_BITS'(-32768));
    send_sample(SAMPLE_BITS'(32767));
    send_sample(SAMPLE_BITS'(-5));
    drain(8);

    // Both at maximum: predicted variance saturates from the second sample on.
    write_noise(REG_MEASUREMENT_NOISE, NOISE_MAX);
    send_sample(SAMPLE_BITS'(32767));
    send_sample(SAMPLE_BITS'(32767));
    send_sample(SAMPLE_BITS'(-32768));
    send_sample(SAMPLE_BITS'(100));
    drain(8);

    // No Q, huge R: nonzero denominator but gain stays 0.
    write_noise(REG_PROCESS_NOISE, '0);
    send_sample(SAMPLE_BITS'(32767));
    send_sample(SAMPLE_BITS'(-32768));
    send_sample(SAMPLE_BITS'(7));
    drain(8);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       write_noise(REG_PROCESS_NOISE, pick_noise());
        1:       write_noise(REG_MEASUREMENT_NOISE, pick_noise());
        default: begin
          write_noise(REG_PROCESS_NOISE, pick_noise());
          write_noise(REG_MEASUREMENT_NOISE, pick_noise());
        end
      endcase
      level   = int'($urandom_range(0, 65535)) - 32768;
      n_items = $urandom_range(20, 160);
      repeat (n_items) begin
        // Occasionally step the level so the filter has to track.
        if ($urandom_range(0, 49) == 0) level = int'($urandom_range(0, 65535)) - 32768;
        send_sample(pick_sample(level));
        sent++;
      end
      drain(8);
    end

    drain(RESULT_DELAY);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/skf_pkg.sv
hw/rtl/skf_seq.sv
hw/rtl/skf_dp.sv
hw/rtl/scalar_kalman_filter_unit.sv
dv/scalar_kalman_filter_unit_tb.sv
